FILE: rtl/core/vnf_pkg.sv
// shared types, hash constants and helpers for the value noise fbm block
// no dependencies; imported by vnf_cell, value_noise_fbm and tb_top
package vnf_pkg;

   // register stages inside one octave cell
   localparam int CELL_STAGES = 12;

   // lattice hash constants
   localparam logic [31:0] HASH_MUL_X  = 32'd1619;
   localparam logic [31:0] HASH_MUL_Y  = 32'd31337;
   localparam logic [31:0] HASH_SQ_MUL = 32'd15731;
   localparam logic [31:0] HASH_ADD    = 32'd789221;
   localparam logic [31:0] HASH_OFS    = 32'd1376312589;
   localparam logic [31:0] HASH_MASK   = 32'h7fff_ffff;

   // 1.0 in q2.30
   localparam logic [31:0] CORNER_ONE  = 32'h4000_0000;

   // 1.0 in q1.16 and 3.0 in q2.16 for smoothstep
   localparam logic [16:0] WEIGHT_ONE  = 17'h1_0000;
   localparam logic [17:0] SMOOTH_3    = 18'h3_0000;

   localparam int OUT_W = 18;

   typedef struct packed {
      logic        valid;
      logic [31:0] coord_x;
      logic [31:0] coord_y;
      logic [3:0]  octaves;
   } ctx_type;

   function automatic logic [31:0] hash_scramble(input logic [31:0] n);
      return (n << 13) ^ n;
   endfunction

endpackage

FILE: rtl/core/value_noise_fbm.sv
// value noise fbm: one octave cell per octave, chained, each 12 stages deep
// request beats pass through the stage registers of each cell in turn
// throughput one beat per cycle; the whole chain holds while a response is stalled
// synchronous active-high reset clears the valid bits of every stage
// depends on vnf_pkg and vnf_cell
module value_noise_fbm
   import vnf_pkg::*;
#(
   parameter int MAX_OCTAVES = 8
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic signed [31:0]       req_coord_x,
   input  logic signed [31:0]       req_coord_y,
   input  logic [3:0]               req_octave_count,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [OUT_W-1:0]  rsp_noise_value
);

   // sum is kept in units of 2^-(62 + MAX_OCTAVES)
   localparam int ACC_W  = 64 + MAX_OCTAVES;
   localparam int OUT_LO = 46 + MAX_OCTAVES;

   ctx_type          ctx_c [0:MAX_OCTAVES];
   logic [ACC_W-1:0] acc_c [0:MAX_OCTAVES];
   logic             advance;

   // whole chain moves unless the final beat is held by the consumer
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   // head of chain: new beat enters with an empty sum
   assign ctx_c[0].valid   = req_valid;
   assign ctx_c[0].coord_x = req_coord_x;
   assign ctx_c[0].coord_y = req_coord_y;
   assign ctx_c[0].octaves = req_octave_count;
   assign acc_c[0]         = '0;

   // cell i adds octave i at weight 2^-(i+1); counts above the chain length
   // simply enable every cell
   for (genvar i = 0; i < MAX_OCTAVES; i++) begin : g_cell
      vnf_cell #(
         .OCT_INDEX   (i),
         .MAX_OCTAVES (MAX_OCTAVES),
         .ACC_W       (ACC_W)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .ctx_in  (ctx_c[i]),
         .acc_in  (acc_c[i]),
         .ctx_out (ctx_c[i+1]),
         .acc_out (acc_c[i+1])
      );
   end

   // last cell's output register is the response register; the arithmetic
   // shift here is the floor to q1.16
   assign rsp_valid       = ctx_c[MAX_OCTAVES].valid;
   assign rsp_noise_value = $signed(acc_c[MAX_OCTAVES][OUT_LO+OUT_W-1:OUT_LO]);

`ifndef NO_ASSERTIONS
   // the sum of octaves never leaves [-1, 1]
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_noise_value >= -18'sd65536 && rsp_noise_value <= 18'sd65536)
      else $error("noise value out of range");

   // nothing comes out right after reset
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response beat after reset");

   // a stalled response holds the final beat and its sum in place
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(acc_c[MAX_OCTAVES]))
      else $error("chain moved under a stalled response");
`endif

endmodule

FILE: rtl/core/vnf_cell.sv
// one octave cell: lattice hash, smoothstep blend and accumulate
// depends on vnf_pkg
module vnf_cell
   import vnf_pkg::*;
#(
   parameter int OCT_INDEX   = 0,
   parameter int MAX_OCTAVES = 8,
   parameter int ACC_W       = 64 + MAX_OCTAVES
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  ctx_type          ctx_in,
   input  logic [ACC_W-1:0] acc_in,
   output ctx_type          ctx_out,
   output logic [ACC_W-1:0] acc_out
);

   localparam int SH = MAX_OCTAVES - 1 - OCT_INDEX;
   localparam int NS = CELL_STAGES;

   ctx_type          ctx_ff [1:NS];
   logic [ACC_W-1:0] acc_ff [1:NS-1];
   logic [ACC_W-1:0] acc_out_ff;

   // stage 0 combinational: scaled coordinate, hash products and fraction squares
   logic [47:0] px_w, py_w;
   logic [31:0] ix_w, iy_w, ax_w, ay_w, ffx_w, ffy_w;
   logic [15:0] fx_w, fy_w;

   assign px_w  = {{16{ctx_in.coord_x[31]}}, ctx_in.coord_x} << OCT_INDEX;
   assign py_w  = {{16{ctx_in.coord_y[31]}}, ctx_in.coord_y} << OCT_INDEX;
   assign ix_w  = px_w[47:16];
   assign iy_w  = py_w[47:16];
   assign fx_w  = px_w[15:0];
   assign fy_w  = py_w[15:0];
   assign ax_w  = ix_w * HASH_MUL_X;
   assign ay_w  = iy_w * HASH_MUL_Y;
   assign ffx_w = {16'b0, fx_w} * {16'b0, fx_w};
   assign ffy_w = {16'b0, fy_w} * {16'b0, fy_w};

   logic [31:0] ax1_ff, ay1_ff, ffx1_ff, ffy1_ff;
   logic [15:0] fx1_ff, fy1_ff;

   // stage 2: corner seeds and smoothstep products
   logic [31:0] base_w;
   logic [31:0] n_w [4];
   logic [47:0] pwx_w, pwy_w;

   assign base_w = ax1_ff + ay1_ff;
   assign n_w[0] = base_w;
   assign n_w[1] = base_w + HASH_MUL_X;
   assign n_w[2] = base_w + HASH_MUL_Y;
   assign n_w[3] = base_w + HASH_MUL_X + HASH_MUL_Y;
   assign pwx_w  = {16'b0, ffx1_ff} * {30'b0, SMOOTH_3 - {1'b0, fx1_ff, 1'b0}};
   assign pwy_w  = {16'b0, ffy1_ff} * {30'b0, SMOOTH_3 - {1'b0, fy1_ff, 1'b0}};

   logic [31:0] n2_ff [4];
   logic [31:0] n3_ff [4];
   logic [31:0] n4_ff [4];
   logic [31:0] sq3_ff [4];
   logic [31:0] u4_ff [4];
   logic [31:0] v5_ff [4];
   logic [31:0] corner6_ff [4];
   logic [15:0] wx_ff [2:6];
   logic [15:0] wy_ff [2:8];

   // stage 7: corner times horizontal weight
   logic [16:0]        wxc_w;
   logic signed [48:0] p7_w [4];

   assign wxc_w   = WEIGHT_ONE - {1'b0, wx_ff[6]};
   assign p7_w[0] = $signed({{17{corner6_ff[0][31]}}, corner6_ff[0]})
                    * $signed({32'b0, wxc_w});
   assign p7_w[1] = $signed({{17{corner6_ff[1][31]}}, corner6_ff[1]})
                    * $signed({33'b0, wx_ff[6]});
   assign p7_w[2] = $signed({{17{corner6_ff[2][31]}}, corner6_ff[2]})
                    * $signed({32'b0, wxc_w});
   assign p7_w[3] = $signed({{17{corner6_ff[3][31]}}, corner6_ff[3]})
                    * $signed({33'b0, wx_ff[6]});

   logic signed [48:0] p7_ff [4];
   logic signed [49:0] top8_ff, bot8_ff;

   // stage 9: row times vertical weight, split in two partial products
   logic [16:0]        wyc_w;
   logic signed [41:0] th9_w, bh9_w;
   logic [41:0]        tl9_w, bl9_w;

   assign wyc_w = WEIGHT_ONE - {1'b0, wy_ff[8]};
   assign th9_w = $signed({{17{top8_ff[49]}}, top8_ff[49:25]})
                  * $signed({25'b0, wyc_w});
   assign tl9_w = {17'b0, top8_ff[24:0]} * {25'b0, wyc_w};
   assign bh9_w = $signed({{17{bot8_ff[49]}}, bot8_ff[49:25]})
                  * $signed({26'b0, wy_ff[8]});
   assign bl9_w = {17'b0, bot8_ff[24:0]} * {26'b0, wy_ff[8]};

   logic signed [41:0] th9_ff, bh9_ff;
   logic [41:0]        tl9_ff, bl9_ff;
   logic [63:0]        ptop10_ff, pbot10_ff;
   logic [63:0]        s11_ff;

   // stage 12: accumulate when this octave is in range
   logic             use_w;
   logic [ACC_W-1:0] term_w;

   assign use_w  = ctx_ff[NS-1].octaves > 4'(OCT_INDEX);
   assign term_w = {{MAX_OCTAVES{s11_ff[63]}}, s11_ff} << SH;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= NS; k++) begin
            ctx_ff[k].valid <= 1'b0;
         end
      end else if (advance) begin
         ctx_ff[1] <= ctx_in;
         for (int k = 2; k <= NS; k++) begin
            ctx_ff[k] <= ctx_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         acc_ff[1] <= acc_in;
         for (int k = 2; k <= NS - 1; k++) begin
            acc_ff[k] <= acc_ff[k-1];
         end
         acc_out_ff <= use_w ? acc_ff[NS-1] + term_w : acc_ff[NS-1];

         ax1_ff  <= ax_w;
         ay1_ff  <= ay_w;
         ffx1_ff <= ffx_w;
         ffy1_ff <= ffy_w;
         fx1_ff  <= fx_w;
         fy1_ff  <= fy_w;

         wx_ff[2] <= pwx_w[47:32];
         wy_ff[2] <= pwy_w[47:32];
         for (int k = 3; k <= 6; k++) begin
            wx_ff[k] <= wx_ff[k-1];
         end
         for (int k = 3; k <= 8; k++) begin
            wy_ff[k] <= wy_ff[k-1];
         end

         for (int c = 0; c < 4; c++) begin
            n2_ff[c]      <= hash_scramble(n_w[c]);
            n3_ff[c]      <= n2_ff[c];
            n4_ff[c]      <= n3_ff[c];
            sq3_ff[c]     <= n2_ff[c] * n2_ff[c];
            u4_ff[c]      <= sq3_ff[c] * HASH_SQ_MUL + HASH_ADD;
            v5_ff[c]      <= n4_ff[c] * u4_ff[c];
            corner6_ff[c] <= CORNER_ONE - ((v5_ff[c] + HASH_OFS) & HASH_MASK);
            p7_ff[c]      <= p7_w[c];
         end

         top8_ff <= {p7_ff[0][48], p7_ff[0]} + {p7_ff[1][48], p7_ff[1]};
         bot8_ff <= {p7_ff[2][48], p7_ff[2]} + {p7_ff[3][48], p7_ff[3]};

         th9_ff <= th9_w;
         tl9_ff <= tl9_w;
         bh9_ff <= bh9_w;
         bl9_ff <= bl9_w;

         ptop10_ff <= ({{22{th9_ff[41]}}, th9_ff} << 25) + {22'b0, tl9_ff};
         pbot10_ff <= ({{22{bh9_ff[41]}}, bh9_ff} << 25) + {22'b0, bl9_ff};

         s11_ff <= ptop10_ff + pbot10_ff;
      end
   end

   assign ctx_out = ctx_ff[NS];
   assign acc_out = acc_out_ff;

`ifndef NO_ASSERTIONS
   // an octave beyond the count leaves the sum untouched
   assert property (@(posedge clock) disable iff (reset)
      advance && ctx_ff[NS-1].valid && !use_w |=> acc_out_ff == $past(acc_ff[NS-1]))
      else $error("skipped octave changed the sum");

   // a beat moves through the last stage when the chain advances
   assert property (@(posedge clock) disable iff (reset)
      advance && ctx_ff[NS-1].valid |=> ctx_ff[NS].valid)
      else $error("beat lost in cell");
`endif

endmodule

FILE: sim/tb_top.sv
// self-checking testbench for value_noise_fbm: directed and random coordinates
// predicts each noise value in 128-bit exact fixed point; depends on vnf_pkg and the rtl
module tb_top
   import vnf_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int OCT_LIMIT = 8;
   localparam int LATENCY   = 12 * OCT_LIMIT;
   localparam int WATCHDOG  = 4000;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   logic signed [31:0]      req_coord_x = '0;
   logic signed [31:0]      req_coord_y = '0;
   logic [3:0]              req_octave_count = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   logic signed [OUT_W-1:0] rsp_noise_value;

   logic signed [OUT_W-1:0] noise_expected[$];
   int  error_count = 0;
   int  quiet_cycles = 0;
   bit  idle_enable = 1'b1;

   value_noise_fbm #(.MAX_OCTAVES(OCT_LIMIT)) uut (.*);

   always #10 clock = ~clock;

   // lattice hash to q2.30 corner value
   function automatic logic signed [63:0] lattice_corner(input logic [31:0] ix,
                                                         input logic [31:0] iy);
      logic [31:0] n, t;
      n = ix * 32'd1619 + iy * 32'd31337;
      n = (n << 13) ^ n;
      t = (n * (n * n * 32'd15731 + 32'd789221) + 32'd1376312589) & 32'h7fff_ffff;
      return 64'sd1073741824 - $signed({32'd0, t});
   endfunction

   // smoothstep in q0.16
   function automatic logic signed [63:0] fade_weight(input logic [63:0] f);
      logic [63:0] p;
      p = f * f * (64'd196608 - 2 * f);
      return $signed(p >> 32);
   endfunction

   // exact fbm sum floored to q1.16; everything held in 128-bit signed
   function automatic logic signed [OUT_W-1:0] fbm_predict(input logic signed [31:0] cx,
         input logic signed [31:0] cy, input logic [3:0] cnt);
      logic signed [127:0] total, px, py, ipx, ipy, wx, wy, a, b, c, d, top, bot, s;
      int n;
      total = 0;
      n = (cnt > OCT_LIMIT) ? OCT_LIMIT : cnt;
      for (int i = 0; i < n; i++) begin
         px = 128'(cx) <<< i;
         py = 128'(cy) <<< i;
         ipx = px >>> 16;
         ipy = py >>> 16;
         wx = fade_weight(64'(px - (ipx <<< 16)));
         wy = fade_weight(64'(py - (ipy <<< 16)));
         a = lattice_corner(ipx[31:0], ipy[31:0]);
         b = lattice_corner(ipx[31:0] + 1, ipy[31:0]);
         c = lattice_corner(ipx[31:0], ipy[31:0] + 1);
         d = lattice_corner(ipx[31:0] + 1, ipy[31:0] + 1);
         top = a * (65536 - wx) + b * wx;
         bot = c * (65536 - wx) + d * wx;
         s = top * (65536 - wy) + bot * wy;
         // octave i weighs 2^-(i+1); bring to units of 2^-78
         total += s <<< (15 - i);
      end
      return OUT_W'(total >>> 62);
   endfunction

   // one request beat, sometimes after a random gap while idling is enabled
   task automatic send_coord(input logic signed [31:0] cx, input logic signed [31:0] cy,
                             input logic [3:0] cnt);
      if (idle_enable && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_coord_x      <= cx;
      req_coord_y      <= cy;
      req_octave_count <= cnt;
      do @(posedge clock); while (req_stall);
      noise_expected.push_back(fbm_predict(cx, cy, cnt));
   endtask

   task automatic finish_sending;
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   // response stall bursts
   initial begin
      @(posedge clock);
      forever begin
         if (idle_enable && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 18)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
         @(posedge clock);
         if (!idle_enable) rsp_stall <= 1'b0;
      end
   end

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (noise_expected.size() == 0) begin
            $error("noise_value: unexpected beat, actual %0d", rsp_noise_value);
            error_count++;
         end else begin
            if (rsp_noise_value !== noise_expected[0]) begin
               $error("noise_value: expected %0d actual %0d",
                      noise_expected[0], rsp_noise_value);
               error_count++;
            end
            void'(noise_expected.pop_front());
         end
      end
   end

   // watchdog on beats in either direction
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic test_octave_counts;
      for (int k = 0; k < 16; k++) send_coord(32'sh0001_8000, -32'sh0002_4000, k[3:0]);
   endtask

   task automatic test_extremes;
      send_coord(32'sh7fff_ffff, 32'sh7fff_ffff, 4'd8);
      send_coord(32'sh8000_0000, 32'sh8000_0000, 4'd8);
      send_coord(32'sh7fff_ffff, 32'sh8000_0000, 4'd15);
      send_coord(32'sh0, 32'sh0, 4'd8);
      send_coord(-32'sd1, -32'sd1, 4'd8);
      send_coord(32'sh0000_ffff, 32'sh0001_0000, 4'd1);
   endtask

   task automatic test_random(input int n);
      logic signed [31:0] cx, cy;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(0, 2))
            0: begin cx = $urandom; cy = $urandom; end
            // small coordinates near the origin
            1: begin cx = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh4_0000;
                     cy = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh4_0000; end
            default: begin cx = {$urandom_range(0, 1) ? 16'hffff : 16'h0, 16'($urandom)};
                           cy = {$urandom_range(0, 1) ? 16'hffff : 16'h0, 16'($urandom)}; end
         endcase
         send_coord(cx, cy, ($urandom_range(0, 9) == 0) ? 4'($urandom) : 4'($urandom_range(0, 8)));
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_octave_counts();
      test_extremes();
      test_random(1200);
      // last part runs with no idling on either side
      idle_enable = 1'b0;
      test_random(200);
      finish_sending();
      while (noise_expected.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (error_count == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end
endmodule
